// ===== rtl/lps_pkg.sv =====
`default_nettype none

package lps_pkg;

   localparam int LED_COUNT  = 8;
   localparam int PAT_COUNT  = 8;
   localparam int MAX_FRAMES = 9;
   localparam int SEL_W      = 3;
   localparam int FRAME_W    = 4;
   localparam int PERIOD_W   = 16;
   localparam int CSR_IDX_W  = 2;

   typedef logic [LED_COUNT-1:0] led_type;
   typedef logic [SEL_W-1:0]     sel_type;
   typedef logic [FRAME_W-1:0]   frame_type;
   typedef logic [PERIOD_W-1:0]  period_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FLASH_PERIOD = 2'd0,
      REG_FAST_PERIOD  = 2'd1,
      REG_SLOW_PERIOD  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      GRP_FLASH,
      GRP_FAST,
      GRP_SLOW
   } group_type;

   typedef struct packed {
      period_type flash;
      period_type fast;
      period_type slow;
   } periods_type;

   localparam period_type FLASH_PERIOD_RST = 16'd500;
   localparam period_type FAST_PERIOD_RST  = 16'd250;
   localparam period_type SLOW_PERIOD_RST  = 16'd300;

   localparam led_type FRAME_TAB [PAT_COUNT][MAX_FRAMES] = '{
      '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01, 8'h00},
      '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h00},
      '{8'h18, 8'h24, 8'h42, 8'h81, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h81, 8'h42, 8'h24, 8'h18, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h01, 8'h03, 8'h07, 8'h0F, 8'h1F, 8'h3F, 8'h7F, 8'hFF, 8'h00},
      '{8'h81, 8'hC3, 8'hE7, 8'hFF, 8'hE7, 8'hC3, 8'h81, 8'h00, 8'h00},
      '{8'h81, 8'h42, 8'h24, 8'h18, 8'h24, 8'h42, 8'h00, 8'h00, 8'h00}
   };

   localparam frame_type FRAME_CNT [PAT_COUNT] = '{
      4'd2, 4'd8, 4'd8, 4'd4, 4'd4, 4'd9, 4'd8, 4'd6
   };

   localparam group_type PERIOD_GRP [PAT_COUNT] = '{
      GRP_FLASH, GRP_FAST, GRP_FAST, GRP_SLOW,
      GRP_SLOW, GRP_SLOW, GRP_FAST, GRP_SLOW
   };

endpackage

`default_nettype wire

// ===== rtl/lps_if.sv =====
`default_nettype none

interface lps_req_if import lps_pkg::*; ();
   logic    valid;
   logic    ready;
   sel_type switches;

   modport source (output valid, output switches, input ready);
   modport sink (input valid, input switches, output ready);
endinterface

interface lps_rsp_if import lps_pkg::*; ();
   logic    valid;
   logic    ready;
   led_type leds;

   modport source (output valid, output leds, input ready);
   modport sink (input valid, input leds, output ready);
endinterface

`default_nettype wire

// ===== rtl/lps_csr.sv =====
`default_nettype none

module lps_csr import lps_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [PERIOD_W-1:0]  csr_wdata,
   output periods_type               periods
);

   periods_type periods_ff;
   periods_type periods_in;

   always_comb begin
      periods_in = periods_ff;
      if (csr_we) begin
         case (csr_index)
            REG_FLASH_PERIOD: periods_in.flash = csr_wdata;
            REG_FAST_PERIOD:  periods_in.fast  = csr_wdata;
            REG_SLOW_PERIOD:  periods_in.slow  = csr_wdata;
            default:          periods_in = periods_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         periods_ff.flash <= FLASH_PERIOD_RST;
         periods_ff.fast  <= FAST_PERIOD_RST;
         periods_ff.slow  <= SLOW_PERIOD_RST;
      end else begin
         periods_ff <= periods_in;
      end
   end

   assign periods = periods_ff;

endmodule

`default_nettype wire

// ===== rtl/lps_frame_gen.sv =====
`default_nettype none

module lps_frame_gen import lps_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         take,
   input  wire sel_type      switches,
   input  wire periods_type  periods,
   output led_type           leds
);

   logic       busy_ff, busy_in;
   sel_type    sel_ff, sel_in;
   frame_type  frame_ff, frame_in;
   period_type tick_ff, tick_in;

   sel_type    sel;
   frame_type  frame;
   frame_type  frame_lim;
   frame_type  frame_inc;
   period_type tick;
   period_type tick_sum;
   logic       tick_carry;
   period_type period_raw;
   period_type period;
   logic       frame_end;

   always_comb begin
      // an idle block starts a new pattern from the switches of this word
      sel   = busy_ff ? sel_ff : switches;
      frame = busy_ff ? frame_ff : '0;
      tick  = busy_ff ? tick_ff : '0;

      frame_lim = (frame >= frame_type'(MAX_FRAMES)) ? frame_type'(MAX_FRAMES - 1) : frame;
      leds      = FRAME_TAB[sel][frame_lim];

      case (PERIOD_GRP[sel])
         GRP_FLASH: period_raw = periods.flash;
         GRP_FAST:  period_raw = periods.fast;
         GRP_SLOW:  period_raw = periods.slow;
         default:   period_raw = periods.slow;
      endcase
      period = (period_raw == '0) ? period_type'(1) : period_raw;

      {tick_carry, tick_sum} = {1'b0, tick} + {{PERIOD_W{1'b0}}, 1'b1};
      frame_end = tick_carry || (tick_sum >= period);
      frame_inc = frame + frame_type'(1);

      busy_in  = busy_ff;
      sel_in   = sel_ff;
      frame_in = frame_ff;
      tick_in  = tick_ff;
      if (take) begin
         sel_in  = sel;
         busy_in = 1'b1;
         if (frame_end) begin
            tick_in = '0;
            if (frame_inc >= FRAME_CNT[sel]) begin
               frame_in = '0;
               busy_in  = 1'b0;
            end else begin
               frame_in = frame_inc;
            end
         end else begin
            tick_in  = tick_sum;
            frame_in = frame;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         sel_ff   <= '0;
         frame_ff <= '0;
         tick_ff  <= '0;
      end else begin
         busy_ff  <= busy_in;
         sel_ff   <= sel_in;
         frame_ff <= frame_in;
         tick_ff  <= tick_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lps_out_buf.sv =====
`default_nettype none

module lps_out_buf import lps_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire led_type  push_leds,
   output logic          can_push,
   lps_rsp_if.source     rsp
);

   logic    main_v_ff, main_v_in;
   logic    skid_v_ff, skid_v_in;
   led_type main_d_ff, main_d_in;
   led_type skid_d_ff, skid_d_in;
   logic    pop;

   assign can_push = !skid_v_ff;
   assign pop      = main_v_ff && rsp.ready;

   always_comb begin
      main_v_in = main_v_ff;
      skid_v_in = skid_v_ff;
      main_d_in = main_d_ff;
      skid_d_in = skid_d_ff;
      if (pop) begin
         if (skid_v_ff) begin
            main_d_in = skid_d_ff;
            skid_v_in = 1'b0;
         end else begin
            main_v_in = push;
            main_d_in = push_leds;
         end
      end else if (!main_v_ff) begin
         main_v_in = push;
         main_d_in = push_leds;
      end else if (push) begin
         // word waiting downstream, park the new one
         skid_v_in = 1'b1;
         skid_d_in = push_leds;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
      main_d_ff <= main_d_in;
      skid_d_ff <= skid_d_in;
   end

   assign rsp.valid = main_v_ff;
   assign rsp.leds  = main_d_ff;

endmodule

`default_nettype wire

// ===== rtl/led_pattern_sequencer.sv =====
// led pattern sequencer: one request word is one time-base tick
// each tick's led word is registered in the output buffer before it reaches rsp
// one tick per cycle while req is ready; frame state updates in one registered pass
// a two-entry output buffer keeps req ready while one word waits on rsp
// reset: synchronous, clears the pattern state and output buffer and
// restores the period registers to 500, 250 and 300 ticks
`default_nettype none

module led_pattern_sequencer import lps_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   lps_req_if.sink                   req_if,
   lps_rsp_if.source                 rsp_if,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [PERIOD_W-1:0]  csr_wdata
);

   periods_type periods;
   led_type     leds;
   logic        can_push;
   logic        take;

   assign req_if.ready = can_push;
   assign take         = req_if.valid && can_push;

   lps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .periods   (periods)
   );

   lps_frame_gen u_frame_gen (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .switches (req_if.switches),
      .periods  (periods),
      .leds     (leds)
   );

   lps_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_leds (leds),
      .can_push  (can_push),
      .rsp       (rsp_if)
   );

   a_take_gives_word: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_if.valid)
      else $error("accepted tick produced no led word");

   a_stall_has_word: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> rsp_if.valid)
      else $error("request stalled with output buffer empty");

   a_full_stays_full: assert property (@(posedge clock) disable iff (reset)
      (!req_if.ready && !rsp_if.ready) |=> !req_if.ready)
      else $error("output buffer lost a word while downstream stalled");

endmodule

`default_nettype wire

// ===== tb/sv/lps_frame_checker.sv =====
`timescale 1ns / 1ps

module lps_frame_checker import lps_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   lps_req_if                        req_if,
   lps_rsp_if                        rsp_if,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [PERIOD_W-1:0]  csr_wdata,
   output int                        failures,
   output int                        outstanding
);

   localparam int FRAME_SLOTS = 9;

   localparam led_type SHOW_TAB [8][FRAME_SLOTS] = '{
      '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01, 8'h00},
      '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h00},
      '{8'h18, 8'h24, 8'h42, 8'h81, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h81, 8'h42, 8'h24, 8'h18, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h01, 8'h03, 8'h07, 8'h0F, 8'h1F, 8'h3F, 8'h7F, 8'hFF, 8'h00},
      '{8'h81, 8'hC3, 8'hE7, 8'hFF, 8'hE7, 8'hC3, 8'h81, 8'h00, 8'h00},
      '{8'h81, 8'h42, 8'h24, 8'h18, 8'h24, 8'h42, 8'h00, 8'h00, 8'h00}
   };

   localparam int FRAMES_IN [8] = '{2, 8, 8, 4, 4, 9, 8, 6};

   localparam group_type RATE_OF [8] = '{
      GRP_FLASH, GRP_FAST, GRP_FAST, GRP_SLOW,
      GRP_SLOW, GRP_SLOW, GRP_FAST, GRP_SLOW
   };

   period_type flash_ticks;
   period_type fast_ticks;
   period_type slow_ticks;

   logic       running;
   sel_type    cur_sel;
   frame_type  cur_frame;
   period_type held;

   led_type    leds_due [$];
   led_type    want_leds;

   task automatic report(input string msg);
      $display("%0t: %s", $time, msg);
      failures++;
   endtask

   function automatic period_type frame_ticks(input sel_type p);
      period_type t;
      case (RATE_OF[p])
         GRP_FLASH: t = flash_ticks;
         GRP_FAST:  t = fast_ticks;
         default:   t = slow_ticks;
      endcase
      // a zero period behaves as one tick
      return (t == '0) ? period_type'(1) : t;
   endfunction

   function automatic led_type next_leds(input sel_type sw);
      led_type   shown;
      frame_type f;
      if (!running) begin
         cur_sel   = sw;
         cur_frame = '0;
         held      = '0;
         running   = 1'b1;
      end
      f = (cur_frame >= FRAME_SLOTS) ? frame_type'(FRAME_SLOTS - 1) : cur_frame;
      shown = SHOW_TAB[cur_sel][f];
      held = held + 1'b1;
      // a lowered period ends the frame as soon as the count meets it
      if (held >= frame_ticks(cur_sel) || held == '0) begin
         held = '0;
         cur_frame = cur_frame + 1'b1;
         if (cur_frame >= FRAMES_IN[cur_sel]) begin
            cur_frame = '0;
            running   = 1'b0;
         end
      end
      return shown;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         flash_ticks = 16'd500;
         fast_ticks  = 16'd250;
         slow_ticks  = 16'd300;
         running     = 1'b0;
         cur_sel     = '0;
         cur_frame   = '0;
         held        = '0;
         leds_due.delete();
         failures    = 0;
      end else begin
         // pop before push: a word can never answer the tick taken at the same edge
         if (rsp_if.valid && rsp_if.ready) begin
            if (leds_due.size() == 0) begin
               report($sformatf("led word %02h with no tick pending", rsp_if.leds));
            end else begin
               want_leds = leds_due.pop_front();
               if (rsp_if.leds !== want_leds)
                  report($sformatf("leds %02h, expected %02h", rsp_if.leds, want_leds));
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_FLASH_PERIOD: flash_ticks = csr_wdata;
               REG_FAST_PERIOD:  fast_ticks  = csr_wdata;
               REG_SLOW_PERIOD:  slow_ticks  = csr_wdata;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready)
            leds_due.push_back(next_leds(req_if.switches));
      end
      outstanding = leds_due.size();
   end

endmodule

// ===== tb/sv/tb_led_pattern_sequencer.sv =====
`timescale 1ns / 1ps

module tb_led_pattern_sequencer;
   import lps_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int TICK_TARGET = 500;

   // index past the last register, writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   localparam sel_type PAT_FLASH    = 3'd0;
   localparam sel_type PAT_DOT_DOWN = 3'd1;
   localparam sel_type PAT_DOT_UP   = 3'd2;
   localparam sel_type PAT_SNAKE    = 3'd5;
   localparam sel_type PAT_BOUNCE   = 3'd7;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [PERIOD_W-1:0]  csr_wdata;

   bit req_idle = 1'b1;
   bit rsp_idle = 1'b1;
   int failures;
   int outstanding;
   int cycle_count = 0;
   int ticks_sent = 0;

   lps_req_if req_if ();
   lps_rsp_if rsp_if ();

   led_pattern_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lps_frame_checker frame_check (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_if.ready <= rsp_idle ? ($urandom_range(99) >= 37) : 1'b1;
   end

   task automatic send_tick(input sel_type sw);
      int gap;
      gap = 0;
      if (req_idle)
         while ($urandom_range(99) < 37) gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.switches <= sw;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      ticks_sent++;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input period_type val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic period_type pick_period();
      int r;
      r = $urandom_range(99);
      if (r < 10) return '0;
      if (r < 15) return 16'hFFFF;
      if (r < 25) return period_type'($urandom_range(40, 6));
      return period_type'($urandom_range(5, 1));
   endfunction

   initial begin
      int n;
      int phase;
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.switches <= '0;
      csr_we          <= 1'b0;
      csr_index       <= REG_FLASH_PERIOD;
      csr_wdata       <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // start a bounce pattern on the reset periods
      send_tick(PAT_BOUNCE);
      send_tick(PAT_BOUNCE);
      drain();
      // lower the period mid-frame, switches must be ignored until the pattern ends
      write_reg(REG_SLOW_PERIOD, 16'd1);
      repeat (6) send_tick(PAT_FLASH);
      drain();
      write_reg(REG_FLASH_PERIOD, 16'd0);
      write_reg(REG_FAST_PERIOD, 16'd0);
      write_reg(REG_SPARE, 16'hFFFF);
      send_tick(PAT_FLASH);
      send_tick(PAT_SNAKE);
      send_tick(PAT_DOT_UP);
      repeat (7) send_tick(PAT_SNAKE);
      drain();
      write_reg(REG_FLASH_PERIOD, 16'hFFFF);
      repeat (3) send_tick(PAT_FLASH);
      drain();
      write_reg(REG_FLASH_PERIOD, 16'd1);
      send_tick(PAT_FLASH);
      send_tick(PAT_DOT_DOWN);

      phase = 0;
      while (ticks_sent < TICK_TARGET) begin
         drain();
         write_reg(REG_FLASH_PERIOD, pick_period());
         write_reg(REG_FAST_PERIOD, pick_period());
         write_reg(REG_SLOW_PERIOD, pick_period());
         req_idle = (phase != 3);
         rsp_idle = (phase != 3);
         n = (phase == 3) ? 120 : $urandom_range(60, 20);
         for (int i = 0; i < n; i++) begin
            send_tick(sel_type'($urandom_range(7, 0)));
            // sender holds off until every led word is back
            if (phase % 4 == 1 && i == n / 2)
               drain();
         end
         phase++;
      end
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      drain();
      repeat (4) @(posedge clock);

      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/lps_pkg.sv
rtl/lps_if.sv
rtl/lps_csr.sv
rtl/lps_frame_gen.sv
rtl/lps_out_buf.sv
rtl/led_pattern_sequencer.sv
tb/sv/lps_frame_checker.sv
tb/sv/tb_led_pattern_sequencer.sv
